// File: design/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants
// slot count, key and state types used by the cell chain and the top level
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int unsigned MaxJobs = 16;
  localparam int unsigned SlotW = $clog2(MaxJobs);

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  // one slot's stored job
  typedef struct packed {
    logic        active;
    logic [7:0]  prio;
    logic [31:0] arrival;
    logic [15:0] remaining;
    logic [15:0] burst;
  } slot_t;

endpackage

// File: design/pps_cell.sv
// ----------------------------------------------------------------------------
// pps_cell: one slot of the job ring
// holds one job and hands it to the next cell when the ring rotates
// ----------------------------------------------------------------------------
module pps_cell
  import pps_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  logic  load_i,
  input  slot_t load_data_i,
  input  slot_t prev_i,
  output slot_t data_o
);

  slot_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (shift_i) begin
      data_d = prev_i;
    end else if (load_i) begin
      data_d = load_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

// File: design/preemptive_priority_scheduler_unit.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit: preemptive priority job scheduler
// an add places a job in a slot; a tick runs the most urgent job one unit
// a tick scans the ring in ST_SCAN, then registers its result in ST_UPDATE
// throughput: one add per cycle while idle; no new item is taken during a tick,
//   which spans a full rotation of the ring past the compare unit and the update;
//   a result still waiting on the output holds the next tick in its update
// reset: all slots inactive, time zero, no clearing pass
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit
  import pps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [3:0]  job_slot_i,
  input  logic [7:0]  job_priority_i,
  input  logic [15:0] job_burst_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ran_o,
  output logic [3:0]  run_slot_o,
  output logic        finished_o,
  output logic [31:0] completion_time_o,
  output logic [31:0] turnaround_o,
  output logic [31:0] waiting_o
);

  // ring of cells: cell 0 feeds from the last cell; head is cell 0
  slot_t cell_q [MaxJobs];
  logic  shift;
  logic  [MaxJobs-1:0] load;
  slot_t load_data;

  state_e state_q, state_d;
  logic [SlotW:0]   cnt_q, cnt_d;    // rotations done
  logic [31:0]      time_q, time_d;
  logic             found_q, found_d;
  logic [SlotW-1:0] best_q, best_d;
  logic [7:0]       bprio_q, bprio_d;
  logic [31:0]      barr_q, barr_d;
  logic             oval_q, oval_d;
  logic             ran_q, ran_d, fin_q, fin_d;
  logic [SlotW-1:0] rslot_q, rslot_d;
  logic [31:0]      ct_q, ct_d, tat_q, tat_d, wt_q, wt_d;

  // slot id of the head cell after cnt rotations
  logic [SlotW-1:0] head_id;
  assign head_id = SlotW'(MaxJobs - 1 - 32'(cnt_q[SlotW-1:0])) + SlotW'(1);

  genvar g;
  for (g = 0; g < MaxJobs; g++) begin : g_cell
    pps_cell u_cell (
      .clk_i,
      .rst_ni,
      .shift_i     (shift),
      .load_i      (load[g]),
      .load_data_i (load_data),
      .prev_i      (cell_q[(g + MaxJobs - 1) % MaxJobs]),
      .data_o      (cell_q[g])
    );
  end

  logic add_ok;
  assign in_ready_o = (state_q == ST_IDLE);
  assign add_ok = in_valid_i && in_ready_o && (operation_i == OP_ADD) &&
                  (32'(job_slot_i) < MaxJobs) && (job_burst_i != '0) &&
                  !cell_q[job_slot_i[SlotW-1:0]].active;

  slot_t head, upd;
  logic  better;
  logic [31:0] t1, tat;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; time_d = time_q;
    found_d = found_q; best_d = best_q; bprio_d = bprio_q; barr_d = barr_q;
    oval_d = oval_q; ran_d = ran_q; fin_d = fin_q; rslot_d = rslot_q;
    ct_d = ct_q; tat_d = tat_q; wt_d = wt_q;
    shift = 1'b0; load = '0; load_data = '0;
    head = cell_q[0];
    upd = cell_q[best_q];
    t1 = time_q + 32'd1;
    tat = t1 - upd.arrival;
    // lower key wins; slots pass in the order 0, 15, 14 .. 1, so a tie on
    // priority and arrival falls to the lower slot id
    better = head.active && (!found_q || (head.prio < bprio_q) ||
             ((head.prio == bprio_q) && ((head.arrival < barr_q) ||
              ((head.arrival == barr_q) && (head_id < best_q)))));
    if (out_ready_i) oval_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (operation_i == OP_TICK) begin
            state_d = ST_SCAN; cnt_d = '0; found_d = 1'b0;
          end else if (add_ok) begin
            load[job_slot_i[SlotW-1:0]] = 1'b1;
            load_data = '{active: 1'b1, prio: job_priority_i, arrival: time_q,
                          remaining: job_burst_i, burst: job_burst_i};
          end
        end
      end
      ST_SCAN: begin
        // compare the head cell, then rotate the ring by one
        if (better) begin
          found_d = 1'b1; best_d = head_id; bprio_d = head.prio;
          barr_d = head.arrival;
        end
        shift = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (SlotW+1)'(MaxJobs - 1)) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        // wait here while the previous result is still held
        if (!oval_q || out_ready_i) begin
          time_d = t1;
          ran_d = found_q; rslot_d = found_q ? best_q : '0;
          fin_d = 1'b0; ct_d = '0; tat_d = '0; wt_d = '0;
          if (found_q) begin
            load[best_q] = 1'b1;
            load_data = upd;
            load_data.remaining = upd.remaining - 16'd1;
            if (upd.remaining == 16'd1) begin
              load_data.active = 1'b0;
              fin_d = 1'b1; ct_d = t1; tat_d = tat; wt_d = tat - 32'(upd.burst);
            end
          end
          oval_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cnt_q <= '0; time_q <= '0; found_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; time_q <= time_d;
      found_q <= found_d; oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d; bprio_q <= bprio_d; barr_q <= barr_d;
    ran_q <= ran_d; fin_q <= fin_d; rslot_q <= rslot_d;
    ct_q <= ct_d; tat_q <= tat_d; wt_q <= wt_d;
  end

  assign out_valid_o       = oval_q;
  assign ran_o             = ran_q;
  assign run_slot_o        = 4'(rslot_q);
  assign finished_o        = fin_q;
  assign completion_time_o = ct_q;
  assign turnaround_o      = tat_q;
  assign waiting_o         = wt_q;

  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cnt_q == (SlotW+1)'(MaxJobs - 1)) |=> state_q == ST_UPDATE)
    else $error("scan length wrong");
  a_fin_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> ran_o)
    else $error("finish without run");
  a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && (!oval_q || out_ready_i)) |=>
      time_q == $past(time_q) + 32'd1)
    else $error("time step wrong");

endmodule

// File: dv/pps_checker.sv
// ----------------------------------------------------------------------------
// pps_checker: scheduler result checker
// watches both channels, keeps its own copy of the slot table and time,
// predicts each tick's outcome and compares it with the block's results
// ----------------------------------------------------------------------------
module pps_checker
  import pps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        operation_i,
  input  logic [3:0]  job_slot_i,
  input  logic [7:0]  job_priority_i,
  input  logic [15:0] job_burst_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        ran_i,
  input  logic [3:0]  run_slot_i,
  input  logic        finished_i,
  input  logic [31:0] completion_time_i,
  input  logic [31:0] turnaround_i,
  input  logic [31:0] waiting_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic        ran;
    logic [3:0]  run_slot;
    logic        finished;
    logic [31:0] completion_time;
    logic [31:0] turnaround;
    logic [31:0] waiting;
  } tick_res_t;

  slot_t       jobs [MaxJobs];
  logic [31:0] now;
  tick_res_t   tick_q [$];

  assign pending_o = tick_q.size();

  // lowest (priority, arrival, slot) key wins
  function automatic logic more_urgent(int a, int b);
    if (jobs[a].prio != jobs[b].prio) return jobs[a].prio < jobs[b].prio;
    if (jobs[a].arrival != jobs[b].arrival) return jobs[a].arrival < jobs[b].arrival;
    return a < b;
  endfunction

  function automatic tick_res_t run_tick();
    tick_res_t r;
    int        best;
    best = -1;
    r = '0;
    for (int k = 0; k < MaxJobs; k++)
      if (jobs[k].active && (best < 0 || more_urgent(k, best))) best = k;
    now = now + 32'd1;
    if (best >= 0) begin
      r.ran = 1'b1;
      r.run_slot = best[3:0];
      jobs[best].remaining = jobs[best].remaining - 16'd1;
      if (jobs[best].remaining == 16'd0) begin
        jobs[best].active = 1'b0;
        r.finished = 1'b1;
        r.completion_time = now;
        r.turnaround = now - jobs[best].arrival;
        r.waiting = r.turnaround - {16'd0, jobs[best].burst};
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_res_t e;
    if (!rst_ni) begin
      for (int k = 0; k < MaxJobs; k++) jobs[k] = '0;
      now = '0;
      tick_q.delete();
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (op_e'(operation_i) == OP_TICK) begin
          tick_q = {tick_q, run_tick()};
        end else if (!jobs[job_slot_i].active && job_burst_i != 16'd0) begin
          jobs[job_slot_i] = '{1'b1, job_priority_i, now, job_burst_i, job_burst_i};
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (tick_q.size() == 0) begin
          $error("unexpected result item");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = tick_q.pop_front();
          if (e.ran != ran_i || e.run_slot != run_slot_i || e.finished != finished_i ||
              e.completion_time != completion_time_i || e.turnaround != turnaround_i ||
              e.waiting != waiting_i) begin
            if (e.ran != ran_i) $error("ran exp %0d got %0d", e.ran, ran_i);
            if (e.run_slot != run_slot_i)
              $error("run_slot exp %0d got %0d", e.run_slot, run_slot_i);
            if (e.finished != finished_i)
              $error("finished exp %0d got %0d", e.finished, finished_i);
            if (e.completion_time != completion_time_i)
              $error("completion_time exp %0d got %0d", e.completion_time,
                     completion_time_i);
            if (e.turnaround != turnaround_i)
              $error("turnaround exp %0d got %0d", e.turnaround, turnaround_i);
            if (e.waiting != waiting_i)
              $error("waiting exp %0d got %0d", e.waiting, waiting_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// File: dv/preemptive_priority_scheduler_unit_test.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit_test: scheduler testbench top
// drives adds and ticks with bursty timing and a stalling receiver; the
// checker predicts every tick result and counts mismatches
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit_test;
  import pps_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        operation_i = 1'b0;
  logic [3:0]  job_slot_i = '0;
  logic [7:0]  job_priority_i = '0;
  logic [15:0] job_burst_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        ran_o;
  logic [3:0]  run_slot_o;
  logic        finished_o;
  logic [31:0] completion_time_o;
  logic [31:0] turnaround_o;
  logic [31:0] waiting_o;
  int          fail_count;
  int          pending;

  // receiver stall pattern is switched by the stimulus process
  bit          hold_off = 1'b0;
  bit          no_stall = 1'b0;
  // length of the hold-off, counted by the receiver itself
  int          hold_cnt = 0;
  bit          hold_done = 1'b0;

  always #10 clk_i = ~clk_i;

  preemptive_priority_scheduler_unit dut (.*);

  pps_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .operation_i,
    .job_slot_i, .job_priority_i, .job_burst_i, .out_valid_i(out_valid_o),
    .out_ready_i, .ran_i(ran_o), .run_slot_i(run_slot_o), .finished_i(finished_o),
    .completion_time_i(completion_time_o), .turnaround_i(turnaround_o),
    .waiting_i(waiting_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stalls, quiet stretches, and one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off && !hold_done) begin
      out_ready_i <= 1'b0;
      if (hold_cnt == 300) hold_done <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else if (no_stall) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // one item: present it, keep it steady until accepted
  task automatic send_item(op_e op, logic [3:0] slot, logic [7:0] prio, logic [15:0] burst);
    in_valid_i <= 1'b1;
    operation_i <= op;
    job_slot_i <= slot;
    job_priority_i <= prio;
    job_burst_i <= burst;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // half ticks; adds are mostly short jobs so many finish, a few long ones and junk adds
  task automatic send_random();
    int sel;
    logic [15:0] burst;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      send_item(OP_TICK, 4'($urandom), 8'($urandom), 16'($urandom));
    end else begin
      if (sel < 85) burst = 16'($urandom_range(1, 6));
      else if (sel < 92) burst = 16'($urandom_range(1, 60));
      else if (sel < 96) burst = 16'($urandom);
      else burst = 16'd0;
      send_item(OP_ADD, 4'($urandom), ($urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                : 8'($urandom)), burst);
    end
  endtask

  initial begin
    int gap;
    bit held;
    bit drained;
    held = 1'b0;
    drained = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle tick, field extremes, ties broken by arrival then slot,
    // add to an active slot, zero burst, preemption by a more urgent job
    send_item(OP_TICK, 4'hf, 8'hff, 16'hffff);
    send_item(OP_ADD, 4'd15, 8'd255, 16'd1);
    send_item(OP_ADD, 4'd0, 8'd255, 16'd2);
    send_item(OP_ADD, 4'd3, 8'd7, 16'd0);
    send_item(OP_ADD, 4'd0, 8'd0, 16'd9);
    send_item(OP_TICK, 4'd0, 8'd0, 16'd0);
    send_item(OP_ADD, 4'd5, 8'd0, 16'd2);
    send_item(OP_TICK, 4'd0, 8'd0, 16'd0);
    send_item(OP_TICK, 4'd0, 8'd0, 16'd0);
    send_item(OP_TICK, 4'd0, 8'd0, 16'd0);
    send_item(OP_ADD, 4'd7, 8'd255, 16'd1);
    send_item(OP_ADD, 4'd9, 8'd0, 16'd1);
    send_item(OP_ADD, 4'd8, 8'd0, 16'd1);
    send_item(OP_TICK, 4'd0, 8'd0, 16'd0);
    send_item(OP_TICK, 4'd0, 8'd0, 16'd0);
    send_item(OP_TICK, 4'd0, 8'd0, 16'd0);
    send_item(OP_TICK, 4'd0, 8'd0, 16'd0);
    send_item(OP_ADD, 4'd10, 8'd1, 16'hffff);
    send_item(OP_TICK, 4'd0, 8'd0, 16'd0);
    send_item(OP_TICK, 4'd0, 8'd0, 16'd0);
    go_idle();

    // random traffic in bursts with gaps
    for (int n = 0; n < 1250; ) begin
      if (n >= 400 && !held) begin
        // long receiver hold-off while ticks keep coming
        held = 1'b1;
        hold_off = 1'b1;
        for (int k = 0; k < 30; k++) begin
          send_item(OP_TICK, 4'd0, 8'd0, 16'd0);
          n++;
        end
        go_idle();
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      if (n >= 700 && !drained) begin
        // drain fully before going on
        drained = 1'b1;
        go_idle();
        while (pending != 0) @(posedge clk_i);
      end
      no_stall = (n >= 900 && n < 1000);
      for (int b = $urandom_range(1, 20); b > 0; b--) begin
        send_random();
        n++;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    go_idle();

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("preemptive_priority_scheduler_unit: match");
    end else begin
      $display("preemptive_priority_scheduler_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("preemptive_priority_scheduler_unit: mismatch");
    $finish;
  end

endmodule
